// File: rtl/reciprocal_sqrt_estimate_top_macros.svh
// Assertion macros for the reciprocal square root estimate block.
// Used by reciprocal_sqrt_estimate_top.sv; expects i_clk and i_rst_n in scope.
`ifndef RECIPROCAL_SQRT_ESTIMATE_TOP_MACROS_SVH
`define RECIPROCAL_SQRT_ESTIMATE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rse_pkg.sv
// Package for the reciprocal square root estimate block: constants and the
// 32-entry base/decrement lookup. No dependencies.
package rse_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] PINF_BITS = 64'h7FF0_0000_0000_0000;
    localparam logic [10:0] EXP_ALL1  = 11'h7FF;
    localparam logic [11:0] EXP_BASE  = 12'd3068;

    typedef logic [4:0]  t_idx;
    typedef logic [25:0] t_base;
    typedef logic [10:0] t_dec;

    function automatic t_base rs_base(input t_idx idx);
        t_base b;
        case (idx)
            5'd0:  b = 26'h1a7e800;  5'd1:  b = 26'h17cb800;
            5'd2:  b = 26'h1552800;  5'd3:  b = 26'h130c000;
            5'd4:  b = 26'h10f2000;  5'd5:  b = 26'h0eff000;
            5'd6:  b = 26'h0d2e000;  5'd7:  b = 26'h0b7c000;
            5'd8:  b = 26'h09e5000;  5'd9:  b = 26'h0867000;
            5'd10: b = 26'h06ff000;  5'd11: b = 26'h05ab800;
            5'd12: b = 26'h046a000;  5'd13: b = 26'h0339800;
            5'd14: b = 26'h0218800;  5'd15: b = 26'h0105800;
            5'd16: b = 26'h3ffa000;  5'd17: b = 26'h3c29000;
            5'd18: b = 26'h38aa000;  5'd19: b = 26'h3572000;
            5'd20: b = 26'h3279000;  5'd21: b = 26'h2fb7000;
            5'd22: b = 26'h2d26000;  5'd23: b = 26'h2ac0000;
            5'd24: b = 26'h2881000;  5'd25: b = 26'h2665000;
            5'd26: b = 26'h2468000;  5'd27: b = 26'h2287000;
            5'd28: b = 26'h20c1000;  5'd29: b = 26'h1f12000;
            5'd30: b = 26'h1d79000;  5'd31: b = 26'h1bf4000;
            default: b = 26'h0;
        endcase
        return b;
    endfunction

    function automatic t_dec rs_dec(input t_idx idx);
        t_dec d;
        case (idx)
            5'd0:  d = 11'h568;  5'd1:  d = 11'h4f3;  5'd2:  d = 11'h48d;
            5'd3:  d = 11'h435;  5'd4:  d = 11'h3e7;  5'd5:  d = 11'h3a2;
            5'd6:  d = 11'h365;  5'd7:  d = 11'h32e;  5'd8:  d = 11'h2fc;
            5'd9:  d = 11'h2d0;  5'd10: d = 11'h2a8;  5'd11: d = 11'h283;
            5'd12: d = 11'h261;  5'd13: d = 11'h243;  5'd14: d = 11'h226;
            5'd15: d = 11'h20b;  5'd16: d = 11'h7a4;  5'd17: d = 11'h700;
            5'd18: d = 11'h670;  5'd19: d = 11'h5f2;  5'd20: d = 11'h584;
            5'd21: d = 11'h524;  5'd22: d = 11'h4cc;  5'd23: d = 11'h47e;
            5'd24: d = 11'h43a;  5'd25: d = 11'h3fa;  5'd26: d = 11'h3c2;
            5'd27: d = 11'h38e;  5'd28: d = 11'h35e;  5'd29: d = 11'h332;
            5'd30: d = 11'h30a;  5'd31: d = 11'h2e6;
            default: d = 11'h0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/reciprocal_sqrt_estimate_top.sv
// Reciprocal square root estimate of an IEEE double, four register stages.
// Throughput 1 item per cycle while the output is not stalled.
// Stages: classify and leading-zero count, normalise and table lookup,
// decrement multiply, interpolate and format into the output register.
// Each stage holds its item under backpressure and fills bubbles.
// Reset (i_rst_n, synchronous, active low) empties every stage.
`include "reciprocal_sqrt_estimate_top_macros.svh"

module reciprocal_sqrt_estimate_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] estimate_bits
);
    import rse_pkg::*;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    // stage 1 payload
    logic        r1_spec;
    logic [63:0] r1_spec_val;
    logic        r1_den;
    logic [5:0]  r1_lzc;
    logic [10:0] r1_exp;
    logic [51:0] r1_frac;

    // stage 2 payload
    logic        r2_spec;
    logic [63:0] r2_spec_val;
    logic [10:0] r2_newexp;
    t_base       r2_base;
    t_dec        r2_dec;
    logic [10:0] r2_k;

    // stage 3 payload
    logic        r3_spec;
    logic [63:0] r3_spec_val;
    logic [10:0] r3_newexp;
    t_base       r3_base;
    logic [21:0] r3_prod;

    // output register
    logic [63:0] r4_data;
    logic        r4_spec;

    assign adv4 = !r_v4 || m_axis_tready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r4_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: classify, leading-zero count ----
    logic        in_sign;
    logic [10:0] in_exp;
    logic [51:0] in_frac;
    logic        n1_spec;
    logic [63:0] n1_spec_val;
    logic [5:0]  n1_lzc;

    assign in_sign = s_axis_tdata[63];
    assign in_exp  = s_axis_tdata[62:52];
    assign in_frac = s_axis_tdata[51:0];

    always_comb begin
        n1_spec     = 1'b1;
        n1_spec_val = QNAN_BITS;
        if (in_exp == 11'd0 && in_frac == 52'd0) begin
            n1_spec_val = {in_sign, PINF_BITS[62:0]};
        end else if (in_exp == EXP_ALL1) begin
            if (in_frac == 52'd0) begin
                n1_spec_val = in_sign ? QNAN_BITS : 64'd0;
            end else begin
                n1_spec_val = s_axis_tdata | 64'h0008_0000_0000_0000;
            end
        end else if (in_sign) begin
            n1_spec_val = QNAN_BITS;
        end else begin
            n1_spec = 1'b0;
        end
    end

    // highest set bit wins; count is 51 - position
    always_comb begin
        n1_lzc = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (in_frac[i]) n1_lzc = 6'(51 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_spec     <= n1_spec;
            r1_spec_val <= n1_spec_val;
            r1_den      <= (in_exp == 11'd0);
            r1_lzc      <= n1_lzc;
            r1_exp      <= in_exp;
            r1_frac     <= in_frac;
        end
    end

    // ---- stage 2: normalise denormals, exponent, table lookup ----
    logic [51:0] n2_frac;
    logic        n2_par;
    logic [11:0] n2_sum;
    logic [6:0]  n2_shamt;
    t_idx        n2_idx;

    assign n2_shamt = {1'b0, r1_lzc} + 7'd1;

    always_comb begin
        if (r1_den) begin
            // exponent becomes -lzc after normalising
            n2_frac = r1_frac << n2_shamt;
            n2_par  = r1_lzc[0];
            n2_sum  = EXP_BASE + {6'd0, r1_lzc};
        end else begin
            n2_frac = r1_frac;
            n2_par  = r1_exp[0];
            n2_sum  = EXP_BASE - {1'b0, r1_exp};
        end
    end

    assign n2_idx = {n2_par, n2_frac[51:48]};

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_spec     <= r1_spec;
            r2_spec_val <= r1_spec_val;
            r2_newexp   <= n2_sum[11:1];
            r2_base     <= rs_base(n2_idx);
            r2_dec      <= rs_dec(n2_idx);
            r2_k        <= n2_frac[47:37];
        end
    end

    // ---- stage 3: decrement times interpolation step ----
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_spec     <= r2_spec;
            r3_spec_val <= r2_spec_val;
            r3_newexp   <= r2_newexp;
            r3_base     <= r2_base;
            r3_prod     <= {11'd0, r2_dec} * {11'd0, r2_k};
        end
    end

    // ---- stage 4: subtract (wraps to 26 bits) and format ----
    t_base n4_val;
    assign n4_val = r3_base - {4'd0, r3_prod};

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_spec <= r3_spec;
            r4_data <= r3_spec ? r3_spec_val : {1'b0, r3_newexp, n4_val, 26'd0};
        end
    end

    // ---- checks ----
    `RSE_ASSERT_NOW(a_ready_only_when_s1_busy, !s_axis_tready, r_v1, "input stalled with stage 1 empty")
    `RSE_ASSERT_NEXT(a_s2_holds_on_stall, r_v2 && !adv3, r_v2 && $stable(r2_newexp), "stage 2 item lost under stall")
    `RSE_ASSERT_NOW(a_normal_result_shape, r_v4 && !r4_spec, !r4_data[63] && r4_data[62:52] != EXP_ALL1 && r4_data[25:0] == 26'd0, "normal estimate malformed")
    `RSE_ASSERT_NEXT(a_out_accept_refills, r_v4 && m_axis_tready && !r_v3, !r_v4, "output repeated after accept")

endmodule

// File: test/reciprocal_sqrt_estimate_checker.sv
// Checker for reciprocal_sqrt_estimate_top: watches both stream channels, predicts
// each estimate from the accepted operand and compares results in order.
// Depends on rse_pkg for the special result patterns.
module reciprocal_sqrt_estimate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  logic        i_op_ready,
    input  logic [63:0] i_op_data,
    input  logic        i_est_valid,
    input  logic        i_est_ready,
    input  logic [63:0] i_est_data,
    output int          o_fail_count,
    output int          o_pending_count
);
    import rse_pkg::*;

    typedef struct {
        logic [63:0] operand;
        logic [63:0] estimate;
    } t_estimate_entry;

    t_estimate_entry pending_estimates[$];
    int              fail_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_estimates.size();

    // Table entry: {base[25:0], step[10:0]}, indexed by {exponent parity, fraction[51:48]}
    function automatic logic [36:0] slope_entry(input logic [4:0] idx);
        logic [36:0] e;
        case (idx)
            5'd0:  e = {26'h1a7e800, 11'h568};
            5'd1:  e = {26'h17cb800, 11'h4f3};
            5'd2:  e = {26'h1552800, 11'h48d};
            5'd3:  e = {26'h130c000, 11'h435};
            5'd4:  e = {26'h10f2000, 11'h3e7};
            5'd5:  e = {26'h0eff000, 11'h3a2};
            5'd6:  e = {26'h0d2e000, 11'h365};
            5'd7:  e = {26'h0b7c000, 11'h32e};
            5'd8:  e = {26'h09e5000, 11'h2fc};
            5'd9:  e = {26'h0867000, 11'h2d0};
            5'd10: e = {26'h06ff000, 11'h2a8};
            5'd11: e = {26'h05ab800, 11'h283};
            5'd12: e = {26'h046a000, 11'h261};
            5'd13: e = {26'h0339800, 11'h243};
            5'd14: e = {26'h0218800, 11'h226};
            5'd15: e = {26'h0105800, 11'h20b};
            5'd16: e = {26'h3ffa000, 11'h7a4};
            5'd17: e = {26'h3c29000, 11'h700};
            5'd18: e = {26'h38aa000, 11'h670};
            5'd19: e = {26'h3572000, 11'h5f2};
            5'd20: e = {26'h3279000, 11'h584};
            5'd21: e = {26'h2fb7000, 11'h524};
            5'd22: e = {26'h2d26000, 11'h4cc};
            5'd23: e = {26'h2ac0000, 11'h47e};
            5'd24: e = {26'h2881000, 11'h43a};
            5'd25: e = {26'h2665000, 11'h3fa};
            5'd26: e = {26'h2468000, 11'h3c2};
            5'd27: e = {26'h2287000, 11'h38e};
            5'd28: e = {26'h20c1000, 11'h35e};
            5'd29: e = {26'h1f12000, 11'h332};
            5'd30: e = {26'h1d79000, 11'h30a};
            default: e = {26'h1bf4000, 11'h2e6};
        endcase
        return e;
    endfunction

    function automatic logic [63:0] predict_rsqrt_estimate(input logic [63:0] operand);
        logic [51:0] frac;
        logic [10:0] exp_field;
        logic        neg;
        int          exp_val;
        int          lead;
        int          half_exp;
        logic [36:0] entry;
        logic [31:0] mant;
        frac      = operand[51:0];
        exp_field = operand[62:52];
        neg       = operand[63];
        if (exp_field == 11'd0 && frac == 52'd0) begin
            return neg ? (PINF_BITS | 64'h8000_0000_0000_0000) : PINF_BITS;
        end
        if (exp_field == EXP_ALL1) begin
            if (frac == 52'd0) begin
                return neg ? QNAN_BITS : 64'd0;
            end
            return operand | 64'h0008_0000_0000_0000;
        end
        if (neg) begin
            return QNAN_BITS;
        end
        exp_val = int'(exp_field);
        if (exp_field == 11'd0) begin
            // denormal: move the leading one up to the hidden position
            lead = 51;
            while (lead > 0 && !frac[lead]) lead--;
            frac    = frac << (52 - lead);
            exp_val = lead - 51;
        end
        half_exp = (3068 - exp_val) >>> 1;
        entry    = slope_entry({exp_val[0], frac[51:48]});
        mant     = {6'd0, entry[36:11]} - 32'(entry[10:0]) * 32'(frac[47:37]);
        return {1'b0, half_exp[10:0], mant[25:0], 26'd0};
    endfunction

    always @(posedge i_clk) begin
        t_estimate_entry head;
        if (i_rst_n) begin
            if (i_op_valid && i_op_ready) begin
                pending_estimates.push_back('{i_op_data, predict_rsqrt_estimate(i_op_data)});
            end
            if (i_est_valid && i_est_ready) begin
                if (pending_estimates.size() == 0) begin
                    $display("%0t: unexpected estimate: expected none, got %h",
                             $time, i_est_data);
                    fail_count++;
                end else begin
                    head = pending_estimates.pop_front();
                    if (i_est_data !== head.estimate) begin
                        $display("%0t: estimate_bits mismatch for operand %h: expected %h, got %h",
                                 $time, head.operand, head.estimate, i_est_data);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: test/reciprocal_sqrt_estimate_top_tb.sv
// Top of the reciprocal_sqrt_estimate_top testbench: clock, reset, operand stimulus
// with random gaps, output back-pressure and the verdict.
// Depends on rse_pkg, reciprocal_sqrt_estimate_top and reciprocal_sqrt_estimate_checker.
module reciprocal_sqrt_estimate_top_tb;
    import rse_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] operand_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] estimate_bits

    int fail_count;
    int pending_count;
    int operands_sent = 0;
    bit hold_done     = 0;

    reciprocal_sqrt_estimate_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    reciprocal_sqrt_estimate_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (s_axis_tvalid),
        .i_op_ready      (s_axis_tready),
        .i_op_data       (s_axis_tdata),
        .i_est_valid     (m_axis_tvalid),
        .i_est_ready     (m_axis_tready),
        .i_est_data      (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        int          r;
        v = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // positive normal; keep away from the all-ones exponent
            v[63] = 1'b0;
            if (v[62:52] == 11'h7FF || v[62:52] == 11'h000)
                v[62:52] = 11'(1 + $urandom_range(0, 2045));
        end else if (r < 67) begin
            v[63:52] = 12'h000;
            if ($urandom_range(0, 1) == 1) v[51:0] = v[51:0] >> $urandom_range(0, 51);
            if (v[51:0] == 52'd0) v[0] = 1'b1;
        end else if (r < 72) begin
            v[62:0] = 63'd0;
        end else if (r < 77) begin
            v[62:52] = EXP_ALL1;
            v[51:0]  = 52'd0;
        end else if (r < 85) begin
            v[62:52] = EXP_ALL1;
            if (v[51:0] == 52'd0) v[$urandom_range(0, 51)] = 1'b1;
        end else if (r < 93) begin
            v[63] = 1'b1;
        end
        return v;
    endfunction

    task automatic send_operand(input logic [63:0] operand, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        do @(posedge i_clk); while (!s_axis_tready);
        operands_sent++;
    endtask

    logic [63:0] directed_ops[$] = '{
        64'h0000_0000_0000_0000,   // +0
        64'h8000_0000_0000_0000,   // -0
        64'h7FF0_0000_0000_0000,   // +inf
        64'hFFF0_0000_0000_0000,   // -inf
        64'h7FF8_0000_0000_0000,   // quiet NaN
        64'h7FF0_0000_0000_0001,   // signalling NaN
        64'hFFF5_5555_AAAA_0001,   // negative NaN with payload
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hBFF0_0000_0000_0000,   // -1.0
        64'h8000_0000_0000_0001,   // negative denormal
        64'h0000_0000_0000_0001,   // smallest denormal
        64'h000F_FFFF_FFFF_FFFF,   // largest denormal
        64'h0008_0000_0000_0000,   // denormal, leading one at top
        64'h0000_0000_0001_2345,
        64'h0010_0000_0000_0000,   // smallest normal
        64'h3FF0_0000_0000_0000,   // 1.0
        64'h4000_0000_0000_0000,   // 2.0
        64'h4010_0000_0000_0000,   // 4.0
        64'h3FFF_FFE0_0000_0000,   // odd exponent, interpolation step at its largest
        64'h4000_FFE0_0000_0000,   // even exponent, same step
        64'h7FEF_FFFF_FFFF_FFFF,   // largest normal
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h0001_0000_0000_0000
    };

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 64'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[i]) send_operand(directed_ops[i], pick_gap());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a stretch without gaps, which also covers the long output hold-off
            send_operand(random_operand(), (n >= 120 && n < 260) ? 0 : pick_gap());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // output side: runs of ready cycles broken by stalls, and one long hold-off
    initial begin
        int run;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && operands_sent >= 150) begin
                hold_done = 1;
                repeat (HOLD_CYCLES) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (run) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
            run = pick_gap();
            repeat (run) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

endmodule
